// ===== hw/rtl/clipped_line_pixel_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the clipped line pixel generator
// Shared concurrent assertion forms, clocked and disabled under reset.
// ----------------------------------------------------------------------------
`ifndef CLIPPED_LINE_PIXEL_GENERATOR_DEFINES_SVH
`define CLIPPED_LINE_PIXEL_GENERATOR_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define CLG_ASSERT_HOLDS(label, clock, reset, expr, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Check a consequence in the cycle after its trigger
`define CLG_ASSERT_NEXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/clg_pkg.sv =====
// ----------------------------------------------------------------------------
// Clipped line pixel generator package
// Widths, codes, shared types and helper functions of the line rasterizer.
// ----------------------------------------------------------------------------
package clg_pkg;

  localparam int COORD_W  = 16;
  localparam int COLOR_W  = 32;
  localparam int ERR_W    = 17;
  localparam int OFFSET_W = 32;
  localparam int BPP_W    = 3;
  localparam int S_DATA_W = 96;
  localparam int M_DATA_W = 96;
  localparam int M_USER_W = 2;
  localparam int APB_DW   = 32;
  localparam int PADDR_W  = 4;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  // Operation codes carried in s_tuser
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Register indexes, paddr[3:2]
  localparam logic [1:0] REG_SURFACE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_SURFACE_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_ROW_PITCH       = 2'd2;
  localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd3;

  // Step direction codes
  localparam logic [1:0] SIGN_ZERO = 2'b00;
  localparam logic [1:0] SIGN_POS  = 2'b01;
  localparam logic [1:0] SIGN_NEG  = 2'b11;

  // Decoded command from the front
  typedef struct packed {
    logic               is_load;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] abs_dx;
    logic [COORD_W-1:0] abs_dy;
    logic [1:0]         sign_x;
    logic [1:0]         sign_y;
    logic               x_major;
  } cmd_t;

  // Raw pixel from the stepper, before clipping and offset
  typedef struct packed {
    logic               pixel_valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pix_t;

  // Surface configuration
  typedef struct packed {
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic [COORD_W-1:0] pitch;
    logic [BPP_W-1:0]   bpp;
  } cfg_t;

  // Move a coordinate one unit in the coded direction, wrapping at 16 bits
  function automatic logic [COORD_W-1:0] step_coord(input logic [COORD_W-1:0] c,
                                                    input logic [1:0] s);
    logic [COORD_W-1:0] r;
    case (s)
      SIGN_POS: r = c + COORD_W'(1);
      SIGN_NEG: r = c - COORD_W'(1);
      default:  r = c;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/clg_regs.sv =====
// ----------------------------------------------------------------------------
// Clipped line pixel generator register file
// APB-style surface configuration registers with read back.
// ----------------------------------------------------------------------------
module clg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [clg_pkg::PADDR_W-1:0] paddr,
  input  logic [clg_pkg::APB_DW-1:0]  pwdata,
  output logic [clg_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output clg_pkg::cfg_t               cfg
);
  import clg_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= COORD_W'(640);
      cfg.height <= COORD_W'(480);
      cfg.pitch  <= COORD_W'(640);
      cfg.bpp    <= BPP_W'(1);
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_SURFACE_WIDTH:   cfg.width  <= pwdata[COORD_W-1:0];
        REG_SURFACE_HEIGHT:  cfg.height <= pwdata[COORD_W-1:0];
        REG_ROW_PITCH:       cfg.pitch  <= pwdata[COORD_W-1:0];
        REG_BYTES_PER_PIXEL: cfg.bpp    <= pwdata[BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[3:2])
      REG_SURFACE_WIDTH:   prdata = APB_DW'(cfg.width);
      REG_SURFACE_HEIGHT:  prdata = APB_DW'(cfg.height);
      REG_ROW_PITCH:       prdata = APB_DW'(cfg.pitch);
      REG_BYTES_PER_PIXEL: prdata = APB_DW'(cfg.bpp);
      default:             prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/clg_front.sv =====
`include "clipped_line_pixel_generator_defines.svh"
// ----------------------------------------------------------------------------
// Clipped line pixel generator front end
// Accepts input beats, classifies load and step, precomputes line deltas
// and queues the decoded commands for the back end.
// ----------------------------------------------------------------------------
module clg_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [clg_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                         s_tuser,
  output logic                         q_valid,
  input  logic                         q_ready,
  output clg_pkg::cmd_t                q_cmd
);
  import clg_pkg::*;

  cmd_t                dec;
  logic [COORD_W:0]    dx;
  logic [COORD_W:0]    dy;
  logic [COORD_W:0]    dx_abs;
  logic [COORD_W:0]    dy_abs;
  cmd_t                queue [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wptr;
  logic [QUEUE_AW-1:0] rptr;
  logic [QUEUE_CW-1:0] count;
  logic                push;
  logic                pop;

  // Decode the beat and work out deltas, directions and the major axis
  always_comb begin
    dec.is_load = (s_tuser == OP_LOAD);
    dec.x_start = s_tdata[15:0];
    dec.y_start = s_tdata[31:16];
    dec.x_end   = s_tdata[47:32];
    dec.y_end   = s_tdata[63:48];
    dec.color   = s_tdata[95:64];
    dx = {dec.x_end[COORD_W-1], dec.x_end} - {dec.x_start[COORD_W-1], dec.x_start};
    dy = {dec.y_end[COORD_W-1], dec.y_end} - {dec.y_start[COORD_W-1], dec.y_start};
    dx_abs = dx[COORD_W] ? -dx : dx;
    dy_abs = dy[COORD_W] ? -dy : dy;
    dec.abs_dx  = dx_abs[COORD_W-1:0];
    dec.abs_dy  = dy_abs[COORD_W-1:0];
    dec.sign_x  = (dx == '0) ? SIGN_ZERO : (dx[COORD_W] ? SIGN_NEG : SIGN_POS);
    dec.sign_y  = (dy == '0) ? SIGN_ZERO : (dy[COORD_W] ? SIGN_NEG : SIGN_POS);
    dec.x_major = (dec.abs_dy < dec.abs_dx);
  end

  assign s_tready = (count != QUEUE_CW'(QUEUE_DEPTH));
  assign q_valid  = (count != '0);
  assign q_cmd    = queue[rptr];
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;

  // Store the decoded command
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wptr] <= dec;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rptr <= rptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + QUEUE_CW'(1);
      end else if (pop && !push) begin
        count <= count - QUEUE_CW'(1);
      end
    end
  end

  `CLG_ASSERT_HOLDS(a_queue_bound, clk, rst, count <= QUEUE_CW'(QUEUE_DEPTH), "queue overfilled")
  `CLG_ASSERT_NEXT(a_queue_grow, clk, rst, push && !pop, count == $past(count) + QUEUE_CW'(1), "queue count lost a push")

endmodule

// ===== hw/rtl/clg_stepper.sv =====
`include "clipped_line_pixel_generator_defines.svh"
// ----------------------------------------------------------------------------
// Clipped line pixel generator stepper
// Holds the active line and walks its Bresenham path, one pixel per step
// command; load commands replace the line.
// ----------------------------------------------------------------------------
module clg_stepper (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  clg_pkg::cmd_t q_cmd,
  output logic          px_valid,
  input  logic          px_ready,
  output clg_pkg::pix_t px
);
  import clg_pkg::*;

  logic [COORD_W-1:0] cur_x, cur_x_next;
  logic [COORD_W-1:0] cur_y, cur_y_next;
  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_y;
  logic [COORD_W-1:0] abs_dx;
  logic [COORD_W-1:0] abs_dy;
  logic [1:0]         sign_x;
  logic [1:0]         sign_y;
  logic [ERR_W-1:0]   error_acc, error_acc_next;
  logic               x_major_phase, x_major_phase_next;
  logic               line_active, line_active_next;
  logic [COLOR_W-1:0] held_color;

  logic               x_walk;
  logic               y_walk;
  logic [ERR_W-1:0]   err_y;
  logic [ERR_W-1:0]   err_sum;
  logic               load_fire;
  logic               step_fire;

  // Pick the branch of the path for the current position
  assign x_walk = x_major_phase && (cur_x != end_x);
  assign y_walk = !x_walk && (cur_y != end_y);
  assign err_y  = x_major_phase ? ERR_W'(abs_dy >> 1) : error_acc;

  // Hand over the current position; zero record when no line is active
  always_comb begin
    px = '0;
    if (line_active) begin
      px.pixel_valid = 1'b1;
      px.x           = cur_x;
      px.y           = cur_y;
      px.color       = held_color;
      px.last        = !x_walk && !y_walk;
    end
  end

  assign px_valid  = q_valid && !q_cmd.is_load;
  assign q_ready   = q_cmd.is_load || px_ready;
  assign load_fire = q_valid && q_ready && q_cmd.is_load;
  assign step_fire = q_valid && q_ready && !q_cmd.is_load;

  // Advance the walk on a step
  always_comb begin
    cur_x_next         = cur_x;
    cur_y_next         = cur_y;
    error_acc_next     = error_acc;
    x_major_phase_next = x_major_phase;
    line_active_next   = line_active;
    err_sum            = '0;
    if (step_fire && line_active) begin
      if (x_walk) begin
        err_sum        = error_acc + ERR_W'(abs_dy);
        error_acc_next = err_sum;
        if (err_sum > ERR_W'(abs_dx)) begin
          error_acc_next = err_sum - ERR_W'(abs_dx);
          cur_y_next     = step_coord(cur_y, sign_y);
        end
        cur_x_next = step_coord(cur_x, sign_x);
      end else if (y_walk) begin
        x_major_phase_next = 1'b0;
        err_sum            = err_y + ERR_W'(abs_dx);
        error_acc_next     = err_sum;
        if (err_sum > ERR_W'(abs_dy)) begin
          error_acc_next = err_sum - ERR_W'(abs_dy);
          cur_x_next     = step_coord(cur_x, sign_x);
        end
        cur_y_next = step_coord(cur_y, sign_y);
      end else begin
        x_major_phase_next = 1'b0;
        error_acc_next     = err_y;
        line_active_next   = 1'b0;
      end
    end
  end

  // Line state: load replaces, step advances
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x         <= '0;
      cur_y         <= '0;
      end_x         <= '0;
      end_y         <= '0;
      abs_dx        <= '0;
      abs_dy        <= '0;
      sign_x        <= SIGN_ZERO;
      sign_y        <= SIGN_ZERO;
      error_acc     <= '0;
      x_major_phase <= 1'b0;
      line_active   <= 1'b0;
      held_color    <= '0;
    end else if (load_fire) begin
      cur_x         <= q_cmd.x_start;
      cur_y         <= q_cmd.y_start;
      end_x         <= q_cmd.x_end;
      end_y         <= q_cmd.y_end;
      abs_dx        <= q_cmd.abs_dx;
      abs_dy        <= q_cmd.abs_dy;
      sign_x        <= q_cmd.sign_x;
      sign_y        <= q_cmd.sign_y;
      error_acc     <= q_cmd.x_major ? ERR_W'(q_cmd.abs_dx >> 1) : ERR_W'(q_cmd.abs_dy >> 1);
      x_major_phase <= q_cmd.x_major;
      line_active   <= 1'b1;
      held_color    <= q_cmd.color;
    end else begin
      cur_x         <= cur_x_next;
      cur_y         <= cur_y_next;
      error_acc     <= error_acc_next;
      x_major_phase <= x_major_phase_next;
      line_active   <= line_active_next;
    end
  end

  `CLG_ASSERT_NEXT(a_last_ends_line, clk, rst, step_fire && px.last, !line_active, "line still active after its last pixel")
  `CLG_ASSERT_NEXT(a_load_starts_line, clk, rst, load_fire, line_active, "load did not start a line")

endmodule

// ===== hw/rtl/clg_pixel_out.sv =====
`include "clipped_line_pixel_generator_defines.svh"
// ----------------------------------------------------------------------------
// Clipped line pixel generator output stage
// Tests each pixel against the surface and forms its byte offset in two
// registered stages: products first, then the sum into the output beat.
// ----------------------------------------------------------------------------
module clg_pixel_out (
  input  logic                         clk,
  input  logic                         rst,
  input  clg_pkg::cfg_t                cfg,
  input  logic                         px_valid,
  output logic                         px_ready,
  input  clg_pkg::pix_t                px,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [clg_pkg::M_DATA_W-1:0] m_tdata,
  output logic [clg_pkg::M_USER_W-1:0] m_tuser,
  output logic                         m_tlast
);
  import clg_pkg::*;

  logic signed [OFFSET_W:0]     row_full;
  logic signed [COORD_W+BPP_W:0] col_full;
  logic                          on_surface;

  logic                s1_valid;
  pix_t                s1_px;
  logic [OFFSET_W-1:0] s1_row;
  logic [OFFSET_W-1:0] s1_col;
  logic                s1_inside;
  logic                s1_ready;
  logic                s2_ready;

  // Products and clip test on the raw pixel
  assign row_full   = $signed({1'b0, cfg.pitch}) * $signed(px.y);
  assign col_full   = $signed(px.x) * $signed({1'b0, cfg.bpp});
  assign on_surface = !px.x[COORD_W-1] && !px.y[COORD_W-1] &&
                      (px.x < cfg.width) && (px.y < cfg.height);

  assign s2_ready = !m_tvalid || m_tready;
  assign s1_ready = !s1_valid || s2_ready;
  assign px_ready = s1_ready;

  // Stage one: register products
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= px_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && px_valid) begin
      s1_px <= px;
      if (px.pixel_valid) begin
        s1_row    <= row_full[OFFSET_W-1:0];
        s1_col    <= {{(OFFSET_W-COORD_W-BPP_W-1){col_full[COORD_W+BPP_W]}}, col_full};
        s1_inside <= on_surface;
      end else begin
        s1_row    <= '0;
        s1_col    <= '0;
        s1_inside <= 1'b0;
      end
    end
  end

  // Stage two: sum into the output beat, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2_ready) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      m_tdata <= {s1_px.color, s1_row + s1_col, s1_px.y, s1_px.x};
      m_tuser <= {s1_inside, s1_px.pixel_valid};
      m_tlast <= s1_px.last;
    end
  end

  `CLG_ASSERT_HOLDS(a_empty_pixel_zero, clk, rst, !(m_tvalid && !m_tuser[0]) || (m_tdata[63:32] == '0 && !m_tuser[1] && !m_tlast), "empty pixel beat carries data")
  `CLG_ASSERT_NEXT(a_stage_hold, clk, rst, s1_valid && !s2_ready, s1_valid && $stable(s1_row), "stage one lost a stalled pixel")

endmodule

// ===== hw/rtl/clipped_line_pixel_generator.sv =====
// Clipped line pixel generator: a load beat (tuser 0) sets a line's signed
// endpoints and color and gives no output; every step beat (tuser 1) gives
// one output beat holding the next Bresenham pixel, its clip flag against
// the surface size and its byte offset, or an all-zero beat when no line is
// active. Sustained rate is one beat per clock in and out while the output
// is not stalled: the stepper updates the line state once per cycle with
// one add, compare and subtract, and the offset is formed in two pipeline
// stages (multiply, then add). An accepted step beat passes through the
// four-entry command queue, stage one and the output registers; a load sets
// the line state. Configure the surface only while the block is idle.
// ----------------------------------------------------------------------------
// Clipped line pixel generator top level
// Wires the register file, front end, stepper and output stage together.
// ----------------------------------------------------------------------------
module clipped_line_pixel_generator (
  input  logic                         clk,
  input  logic                         rst,
  // tdata: x_start[15:0], y_start[31:16], x_end[47:32], y_end[63:48],
  //        line_color[95:64]
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [clg_pkg::S_DATA_W-1:0] s_tdata,
  // tuser: op[0]
  input  logic                         s_tuser,
  // tdata: pixel_x[15:0], pixel_y[31:16], byte_offset[63:32],
  //        pixel_color[95:64]
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [clg_pkg::M_DATA_W-1:0] m_tdata,
  // tuser: pixel_valid[0], inside_res[1]
  output logic [clg_pkg::M_USER_W-1:0] m_tuser,
  // tlast: last_pixel
  output logic                         m_tlast,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [clg_pkg::PADDR_W-1:0]  paddr,
  input  logic [clg_pkg::APB_DW-1:0]   pwdata,
  output logic [clg_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import clg_pkg::*;

  cfg_t cfg;
  cmd_t q_cmd;
  logic q_valid;
  logic q_ready;
  pix_t px;
  logic px_valid;
  logic px_ready;

  clg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  clg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd)
  );

  clg_stepper u_stepper (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_cmd    (q_cmd),
    .px_valid (px_valid),
    .px_ready (px_ready),
    .px       (px)
  );

  clg_pixel_out u_pixel_out (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .px_valid (px_valid),
    .px_ready (px_ready),
    .px       (px),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== tb/tb_clipped_line_pixel_generator.sv =====
// ----------------------------------------------------------------------------
// Clipped line pixel generator testbench
// Streams line loads and pixel steps into the rasterizer with random gaps and
// output stalls, predicts every pixel beat (path, clip flag, byte offset and
// color) with a local Bresenham walker, and compares each output beat field
// by field. The surface registers are rewritten over the APB port between
// phases, the extremes among them.
// ----------------------------------------------------------------------------
module tb_clipped_line_pixel_generator;
  import clg_pkg::*;

  // One command on the input stream
  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic [COLOR_W-1:0] color;
  } draw_cmd_t;

  // One pixel beat on the output stream
  typedef struct packed {
    logic                valid;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic                in_bounds;
    logic [OFFSET_W-1:0] offset;
    logic [COLOR_W-1:0]  color;
    logic                last;
  } pixel_beat_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;
  logic                m_tlast;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  clipped_line_pixel_generator uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Surface settings as the block should hold them
  logic [COORD_W-1:0] cfg_width  = 16'd640;
  logic [COORD_W-1:0] cfg_height = 16'd480;
  logic [COORD_W-1:0] cfg_pitch  = 16'd640;
  logic [BPP_W-1:0]   cfg_bpp    = 3'd1;

  // Line walker state
  logic [COORD_W-1:0] pos_x, pos_y, stop_x, stop_y, run_dx, run_dy;
  logic [1:0]         dir_x, dir_y;
  logic [ERR_W-1:0]   err_term;
  logic               walking_x, line_live;
  logic [COLOR_W-1:0] line_rgba;

  draw_cmd_t   pending_cmds[$];
  pixel_beat_t expected_pixels[$];
  pixel_beat_t oldest_pixel;

  int  beats_queued   = 0;
  int  beats_accepted = 0;
  int  mismatches     = 0;
  int  loads_seen     = 0;
  int  steps_seen     = 0;
  int  idle_steps     = 0;
  int  inside_pixels  = 0;
  int  lines_done     = 0;
  int  send_wait      = 0;
  int  recv_wait      = 0;
  logic idle_sender   = 1'b0;
  logic idle_receiver = 1'b0;
  logic in_fire       = 1'b0;
  logic out_fire      = 1'b0;

  // Move a coordinate one unit in the coded direction, wrapping at 16 bits
  function automatic logic [COORD_W-1:0] nudge(input logic [COORD_W-1:0] c,
                                               input logic [1:0] d);
    case (d)
      SIGN_POS: return c + 16'd1;
      SIGN_NEG: return c - 16'd1;
      default:  return c;
    endcase
  endfunction

  function automatic logic [1:0] dir_of(input int d);
    return (d > 0) ? SIGN_POS : ((d < 0) ? SIGN_NEG : SIGN_ZERO);
  endfunction

  // Build the beat for the current position: clip flag and byte offset
  function automatic pixel_beat_t pixel_here(input logic last);
    pixel_beat_t p;
    logic [31:0] x32, y32;
    x32 = {{16{pos_x[15]}}, pos_x};
    y32 = {{16{pos_y[15]}}, pos_y};
    p.valid     = 1'b1;
    p.x         = pos_x;
    p.y         = pos_y;
    p.in_bounds = !pos_x[15] && !pos_y[15] && (pos_x < cfg_width) &&
                  (pos_y < cfg_height);
    p.offset    = {16'd0, cfg_pitch} * y32 + x32 * {29'd0, cfg_bpp};
    p.color     = line_rgba;
    p.last      = last;
    return p;
  endfunction

  // Advance the line walker by one accepted command
  task automatic rasterize_cmd(input draw_cmd_t c);
    int dx, dy;
    pixel_beat_t p;
    if (c.op == OP_LOAD) begin
      dx = int'($signed(c.x1)) - int'($signed(c.x0));
      dy = int'($signed(c.y1)) - int'($signed(c.y0));
      pos_x     = c.x0;
      pos_y     = c.y0;
      stop_x    = c.x1;
      stop_y    = c.y1;
      dir_x     = dir_of(dx);
      dir_y     = dir_of(dy);
      run_dx    = 16'((dx < 0) ? -dx : dx);
      run_dy    = 16'((dy < 0) ? -dy : dy);
      line_rgba = c.color;
      walking_x = run_dy < run_dx;
      err_term  = walking_x ? {1'b0, run_dx >> 1} : {1'b0, run_dy >> 1};
      line_live = 1'b1;
      loads_seen++;
    end else begin
      p = '0;
      steps_seen++;
      if (!line_live) begin
        idle_steps++;
      end else if (walking_x && pos_x != stop_x) begin
        // x-major walk
        p = pixel_here(1'b0);
        err_term = err_term + {1'b0, run_dy};
        if (err_term > {1'b0, run_dx}) begin
          err_term = err_term - {1'b0, run_dx};
          pos_y = nudge(pos_y, dir_y);
        end
        pos_x = nudge(pos_x, dir_x);
      end else begin
        // y walk, entered directly or after the x phase
        if (walking_x) begin
          walking_x = 1'b0;
          err_term  = {1'b0, run_dy >> 1};
        end
        if (pos_y != stop_y) begin
          p = pixel_here(1'b0);
          err_term = err_term + {1'b0, run_dx};
          if (err_term > {1'b0, run_dy}) begin
            err_term = err_term - {1'b0, run_dy};
            pos_x = nudge(pos_x, dir_x);
          end
          pos_y = nudge(pos_y, dir_y);
        end else begin
          p = pixel_here(1'b1);
          line_live = 1'b0;
          lines_done++;
        end
      end
      if (p.in_bounds) inside_pixels++;
      expected_pixels.insert(expected_pixels.size(), p);
    end
  endtask

  // Predict on each accepted input beat
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      in_fire <= 1'b1;
      rasterize_cmd('{s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[47:32],
                      s_tdata[63:48], s_tdata[95:64]});
      beats_accepted++;
    end else begin
      in_fire <= 1'b0;
    end
  end

  // Drive the next command, after a random gap when idling is on
  always @(negedge clk) begin
    draw_cmd_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (send_wait > 0) begin
        send_wait--;
        s_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        nxt = pending_cmds.pop_front();
        s_tvalid  <= 1'b1;
        s_tuser   <= nxt.op;
        s_tdata   <= {nxt.color, nxt.y1, nxt.x1, nxt.y0, nxt.x0};
        send_wait = idle_sender ? $urandom_range(0, 4) : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Stall the output after each beat, for a random gap when idling is on
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (out_fire) recv_wait = idle_receiver ? $urandom_range(0, 4) : 0;
      if (recv_wait > 0) begin
        recv_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  // Compare each output beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      out_fire <= 1'b1;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        $display("%0t: beat with no prediction, expected none, actual %h/%h/%b",
                 $time, m_tdata, m_tuser, m_tlast);
      end else begin
        oldest_pixel = expected_pixels.pop_front();
        check_field("pixel_valid", oldest_pixel.valid, m_tuser[0]);
        check_field("inside_res", oldest_pixel.in_bounds, m_tuser[1]);
        check_field("pixel_x", oldest_pixel.x, m_tdata[15:0]);
        check_field("pixel_y", oldest_pixel.y, m_tdata[31:16]);
        check_field("byte_offset", oldest_pixel.offset, m_tdata[63:32]);
        check_field("pixel_color", oldest_pixel.color, m_tdata[95:64]);
        check_field("last_pixel", oldest_pixel.last, m_tlast);
      end
    end else begin
      out_fire <= 1'b0;
    end
  end

  // Register write: setup cycle, then access cycle until pready
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] word);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_SURFACE_WIDTH:   cfg_width  = word[15:0];
      REG_SURFACE_HEIGHT:  cfg_height = word[15:0];
      REG_ROW_PITCH:       cfg_pitch  = word[15:0];
      REG_BYTES_PER_PIXEL: cfg_bpp    = word[2:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write all four registers; the unused upper bits carry noise
  task automatic set_surface(input int w, input int h, input int pitch, input int bpp);
    apb_write(REG_SURFACE_WIDTH, {16'($urandom), 16'(w)});
    apb_write(REG_SURFACE_HEIGHT, {16'($urandom), 16'(h)});
    apb_write(REG_ROW_PITCH, {16'($urandom), 16'(pitch)});
    apb_write(REG_BYTES_PER_PIXEL, {29'($urandom), 3'(bpp)});
  endtask

  task automatic queue_cmd(input draw_cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
    beats_queued++;
  endtask

  // Step commands carry random data in the unused fields
  task automatic queue_steps(input int n);
    repeat (n) queue_cmd('{OP_STEP, 16'($urandom), 16'($urandom), 16'($urandom),
                           16'($urandom), $urandom});
  endtask

  function automatic draw_cmd_t line_cmd(input int x0, input int y0, input int x1,
                                         input int y1, input logic [31:0] color);
    return '{OP_LOAD, 16'(x0), 16'(y0), 16'(x1), 16'(y1), color};
  endfunction

  function automatic int clamp16(input int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  // Start near the surface, anywhere, or near the signed wrap point
  function automatic logic [COORD_W-1:0] pick_start(input logic [COORD_W-1:0] extent);
    case ($urandom_range(0, 9)) inside
      [0:5]:   return 16'(int'($urandom_range(0, extent + 8)) - 4);
      [6:7]:   return 16'($urandom);
      default: return 16'h7FF0 + 16'($urandom_range(0, 31));
    endcase
  endfunction

  // Random line, mostly short; span is its major length plus one
  task automatic make_line(output draw_cmd_t c, output int span);
    int len, sx, sy, ex, ey;
    c.op  = OP_LOAD;
    c.x0  = pick_start(cfg_width);
    c.y0  = pick_start(cfg_height);
    len   = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 16);
    sx    = int'($signed(c.x0));
    sy    = int'($signed(c.y0));
    ex    = clamp16(sx + int'($urandom_range(0, 2 * len)) - len);
    ey    = clamp16(sy + int'($urandom_range(0, 2 * len)) - len);
    c.x1  = 16'(ex);
    c.y1  = 16'(ey);
    c.color = $urandom;
    span  = ((ex - sx) < 0 ? sx - ex : ex - sx);
    if (((ey - sy) < 0 ? sy - ey : ey - sy) > span) span = (ey - sy) < 0 ? sy - ey : ey - sy;
    span++;
  endtask

  // Mostly whole lines walked to the end, some cut short, some noise
  task automatic queue_random(input int budget);
    draw_cmd_t c;
    int span, target;
    target = beats_queued + budget;
    while (beats_queued < target) begin
      case ($urandom_range(0, 19))
        0: queue_steps(1 + $urandom_range(0, 2));
        1: begin
          make_line(c, span);
          queue_cmd(c);
        end
        default: begin
          make_line(c, span);
          queue_cmd(c);
          if ($urandom_range(0, 7) == 0) span = $urandom_range(0, span);
          else span = span + $urandom_range(0, 1);
          queue_steps(span);
        end
      endcase
    end
  endtask

  // Wait until every command is taken and every pixel has come out
  task automatic wait_drained();
    while (beats_accepted != beats_queued || expected_pixels.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    int phase;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    line_live = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed lines under the reset surface settings
    idle_sender   = 1'b1;
    idle_receiver = 1'b1;
    queue_steps(1);                                        // step with no line
    queue_cmd(line_cmd(0, 0, 5, 4, 32'hFFFF_FFFF));        // x-major
    queue_steps(6);
    queue_cmd(line_cmd(10, 10, 11, 11, 32'h0));            // equal deltas end short
    queue_steps(3);
    queue_cmd(line_cmd(-32768, -32768, 32767, 32767, 32'hA5A5_5A5A));
    queue_steps(2);                                        // replaced while active
    queue_cmd(line_cmd(639, 479, 641, 479, 32'h5A5A_A5A5)); // crosses the right edge
    queue_steps(4);
    queue_cmd(line_cmd(3, -2, 3, 1, 32'h1234_5678));       // vertical, negative y
    queue_steps(4);
    wait_drained();

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        0: ;
        1: set_surface(0, 0, 0, 0);
        2: set_surface(65535, 65535, 65535, 7);
        3: set_surface($urandom_range(1, 800), $urandom_range(1, 600), $urandom,
                       $urandom_range(1, 4));
        4: set_surface($urandom_range(1, 800), $urandom_range(1, 600), $urandom, 5);
        5: set_surface(320, 240, 1280, $urandom_range(2, 4));
        6: set_surface($urandom, $urandom, $urandom, $urandom_range(0, 7));
        default: set_surface(640, 480, 640, 1);
      endcase
      idle_sender   = (phase == 1) ? 1'b0 : (phase == 2) ? 1'b1 : ($urandom_range(0, 3) != 0);
      idle_receiver = (phase == 1) ? 1'b0 : (phase == 2) ? 1'b1 : ($urandom_range(0, 3) != 0);
      // Hold the sender halfway until the output side has caught up
      queue_random(62);
      wait_drained();
      queue_random(62);
      wait_drained();
    end

    $display("Covered %0d loads and %0d steps (%0d with no line) over 8 surface settings",
             loads_seen, steps_seen, idle_steps);
    $display("Saw %0d finished lines and %0d on-surface pixels", lines_done, inside_pixels);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/clg_pkg.sv
hw/rtl/clg_regs.sv
hw/rtl/clg_front.sv
hw/rtl/clg_stepper.sv
hw/rtl/clg_pixel_out.sv
hw/rtl/clipped_line_pixel_generator.sv
tb/tb_clipped_line_pixel_generator.sv
